// ===== rtl/core/xdu_pkg.sv =====
// ============================================================================
// xdu_pkg : shared types and constants of the x86 divide unit
// Operand size and status codes, and the records that travel down the pipe.
// ============================================================================
package xdu_pkg;

    localparam int unsigned N_CELLS = 32;

    // Operand size codes; the unused code is treated as 32-bit.
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Signed quotient limits per operand size.
    localparam logic [31:0] Q8_MAX  = 32'h0000_007F;
    localparam logic [31:0] Q16_MAX = 32'h0000_7FFF;
    localparam logic [31:0] Q32_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic        mode;
        logic [1:0]  size;
        logic [31:0] acc_low;
        logic [31:0] acc_high;
        logic [31:0] divisor;
    } t_req;

    // Side information carried alongside the division.
    typedef struct packed {
        logic        mode;
        logic [1:0]  size;
        logic        vneg;
        logic        qneg;
        logic        dz;
        logic        hi_ovf;
        logic [31:0] acc_low;
        logic [31:0] acc_high;
    } t_ctl;

    // Contents of one division cell.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dmag;
        t_ctl        ctl;
    } t_stage;

    typedef struct packed {
        logic [31:0] new_acc_low;
        logic [31:0] new_acc_high;
        logic [1:0]  status;
    } t_res;

endpackage

// ===== rtl/core/xdu_prep.sv =====
// ============================================================================
// xdu_prep : operand preparation
// Builds the dividend and divisor at the selected size, takes their
// magnitudes, and checks whether the quotient can exceed 32 bits.
// ============================================================================
module xdu_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  xdu_pkg::t_req  i_req,
    output logic           o_valid,
    output xdu_pkg::t_stage o_stage
);

    logic [63:0]     w_dvd;
    logic [63:0]     w_dvd_neg;
    logic [31:0]     w_dsr;
    logic [31:0]     w_dsr_neg;
    logic            w_vsign;
    logic            w_dsign;
    logic            w_vneg;
    logic            w_dneg;

    logic            r_valid_a;
    logic [63:0]     r_vmag;
    logic [31:0]     r_dmag;
    xdu_pkg::t_ctl   r_ctl_a;
    xdu_pkg::t_ctl   n_ctl_a;
    xdu_pkg::t_ctl   n_ctl_b;

    logic            r_valid_b;
    xdu_pkg::t_stage r_stage;

    always_comb begin
        case (i_req.size)
            xdu_pkg::SZ_8: begin
                w_dvd     = {48'd0, i_req.acc_low[15:0]};
                w_dsr     = {24'd0, i_req.divisor[7:0]};
                w_vsign   = i_req.acc_low[15];
                w_dsign   = i_req.divisor[7];
                w_dvd_neg = {48'd0, ~i_req.acc_low[15:0] + 16'd1};
                w_dsr_neg = {24'd0, ~i_req.divisor[7:0] + 8'd1};
            end
            xdu_pkg::SZ_16: begin
                w_dvd     = {32'd0, i_req.acc_high[15:0], i_req.acc_low[15:0]};
                w_dsr     = {16'd0, i_req.divisor[15:0]};
                w_vsign   = i_req.acc_high[15];
                w_dsign   = i_req.divisor[15];
                w_dvd_neg = {32'd0, ~{i_req.acc_high[15:0], i_req.acc_low[15:0]} + 32'd1};
                w_dsr_neg = {16'd0, ~i_req.divisor[15:0] + 16'd1};
            end
            default: begin
                w_dvd     = {i_req.acc_high, i_req.acc_low};
                w_dsr     = i_req.divisor;
                w_vsign   = i_req.acc_high[31];
                w_dsign   = i_req.divisor[31];
                w_dvd_neg = ~{i_req.acc_high, i_req.acc_low} + 64'd1;
                w_dsr_neg = ~i_req.divisor + 32'd1;
            end
        endcase
        w_vneg = i_req.mode & w_vsign;
        w_dneg = i_req.mode & w_dsign;

        n_ctl_a.mode     = i_req.mode;
        n_ctl_a.size     = i_req.size;
        n_ctl_a.vneg     = w_vneg;
        n_ctl_a.qneg     = w_vneg ^ w_dneg;
        n_ctl_a.dz       = (w_dsr == 32'd0);
        n_ctl_a.hi_ovf   = 1'b0;
        n_ctl_a.acc_low  = i_req.acc_low;
        n_ctl_a.acc_high = i_req.acc_high;
    end

    // The quotient exceeds 32 bits when the upper dividend half alone
    // already reaches the divisor.
    always_comb begin
        n_ctl_b        = r_ctl_a;
        n_ctl_b.hi_ovf = (r_vmag[63:32] >= r_dmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vmag  <= w_vneg ? w_dvd_neg : w_dvd;
            r_dmag  <= w_dneg ? w_dsr_neg : w_dsr;
            r_ctl_a <= n_ctl_a;

            // The upper dividend half seeds the partial remainder.
            r_stage.rem  <= r_vmag[63:32];
            r_stage.quo  <= r_vmag[31:0];
            r_stage.dmag <= r_dmag;
            r_stage.ctl  <= n_ctl_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_stage = r_stage;

endmodule

// ===== rtl/core/xdu_cell.sv =====
// ============================================================================
// xdu_cell : one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits, and shifts the quotient bit in.
// ============================================================================
module xdu_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  xdu_pkg::t_stage i_stage,
    output logic            o_valid,
    output xdu_pkg::t_stage o_stage
);

    logic [32:0]     w_trial;
    logic [33:0]     w_diff;
    logic            w_fits;
    xdu_pkg::t_stage n_stage;

    logic            r_valid;
    xdu_pkg::t_stage r_stage;

    always_comb begin
        w_trial = {i_stage.rem, i_stage.quo[31]};
        w_diff  = {1'b0, w_trial} - {2'b00, i_stage.dmag};
        w_fits  = ~w_diff[33];

        n_stage      = i_stage;
        n_stage.rem  = w_fits ? w_diff[31:0] : w_trial[31:0];
        n_stage.quo  = {i_stage.quo[30:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== rtl/core/xdu_post.sv =====
// ============================================================================
// xdu_post : result fix-up
// Restores the signs of quotient and remainder, applies the quotient range
// checks and merges the results into the accumulator registers.
// ============================================================================
module xdu_post (
    input  xdu_pkg::t_stage i_stage,
    output xdu_pkg::t_res   o_res
);

    logic [31:0] w_qm;
    logic [31:0] w_rm;
    logic [31:0] w_q;
    logic [31:0] w_r;
    logic        w_ovf;
    logic [31:0] w_lo;
    logic [31:0] w_hi;

    always_comb begin
        w_qm = i_stage.quo;
        w_rm = i_stage.rem;
        w_q  = i_stage.ctl.qneg ? (~w_qm + 32'd1) : w_qm;
        w_r  = i_stage.ctl.vneg ? (~w_rm + 32'd1) : w_rm;

        // A negative quotient may reach one past the positive limit.
        case (i_stage.ctl.size)
            xdu_pkg::SZ_8: begin
                if (i_stage.ctl.mode) begin
                    w_ovf = i_stage.ctl.qneg ? (w_qm > (xdu_pkg::Q8_MAX + 32'd1))
                                             : (w_qm > xdu_pkg::Q8_MAX);
                end else begin
                    w_ovf = |w_qm[31:8];
                end
                w_lo = {i_stage.ctl.acc_low[31:16], w_r[7:0], w_q[7:0]};
                w_hi = i_stage.ctl.acc_high;
            end
            xdu_pkg::SZ_16: begin
                if (i_stage.ctl.mode) begin
                    w_ovf = i_stage.ctl.qneg ? (w_qm > (xdu_pkg::Q16_MAX + 32'd1))
                                             : (w_qm > xdu_pkg::Q16_MAX);
                end else begin
                    w_ovf = |w_qm[31:16];
                end
                w_lo = {i_stage.ctl.acc_low[31:16], w_q[15:0]};
                w_hi = {i_stage.ctl.acc_high[31:16], w_r[15:0]};
            end
            default: begin
                if (i_stage.ctl.mode) begin
                    w_ovf = i_stage.ctl.hi_ovf |
                            (i_stage.ctl.qneg ? (w_qm > (xdu_pkg::Q32_MAX + 32'd1))
                                              : (w_qm > xdu_pkg::Q32_MAX));
                end else begin
                    w_ovf = i_stage.ctl.hi_ovf;
                end
                w_lo = w_q;
                w_hi = w_r;
            end
        endcase

        if (i_stage.ctl.dz) begin
            o_res.new_acc_low  = i_stage.ctl.acc_low;
            o_res.new_acc_high = i_stage.ctl.acc_high;
            o_res.status       = xdu_pkg::ST_DIVZERO;
        end else if (w_ovf) begin
            o_res.new_acc_low  = i_stage.ctl.acc_low;
            o_res.new_acc_high = i_stage.ctl.acc_high;
            o_res.status       = xdu_pkg::ST_OVERFLOW;
        end else begin
            o_res.new_acc_low  = w_lo;
            o_res.new_acc_high = w_hi;
            o_res.status       = xdu_pkg::ST_DONE;
        end
    end

endmodule

// ===== rtl/core/x86_divide_unit.sv =====
// ============================================================================
// x86_divide_unit : pipelined x86 DIV / IDIV execution unit
// Divides the accumulator pair by a fetched divisor at 8, 16 or 32 bits,
// signed or unsigned, through a row of one-bit restoring division cells.
// ============================================================================
//
//  Channel   Direction  tdata (low bit up)                 tuser (low bit up)
//  --------  ---------  ---------------------------------  ---------------------
//  s (in)    slave      acc_low 32, acc_high 32, divisor   mode 1, operand_size 2
//  m (out)   master     new_acc_low 32, new_acc_high 32    status 2
//
//  One instruction can be accepted on every clock cycle while tready is high.
//  Each transfer passes through the operand preparation registers, the 32
//  division cells and the output register.
//  The synchronous active-low reset clears the valid bits only.
//  When the output is held, a skid register takes one further result; the
//  whole pipe then pauses and the slave side deasserts tready until the skid
//  register has drained.
//
module x86_divide_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // acc_low, acc_high, divisor
    input  logic [2:0]   i_s_tuser,   // mode, operand_size

    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // new_acc_low, new_acc_high
    output logic [1:0]   o_m_tuser    // status
);

    // Pipe advance: the pipe moves whenever the skid register is empty, so
    // a result leaving the last cell always has somewhere to go.
    logic            w_adv;
    xdu_pkg::t_req   w_req;

    logic            w_valid [xdu_pkg::N_CELLS + 1];
    xdu_pkg::t_stage w_stage [xdu_pkg::N_CELLS + 1];

    xdu_pkg::t_res   w_res;
    logic            w_push;
    logic            w_take;

    logic            r_out_valid;
    xdu_pkg::t_res   r_out;
    logic            r_skid_valid;
    xdu_pkg::t_res   r_skid;

    assign w_adv      = ~r_skid_valid;
    assign o_s_tready = w_adv;

    assign w_req.mode     = i_s_tuser[0];
    assign w_req.size     = i_s_tuser[2:1];
    assign w_req.acc_low  = i_s_tdata[31:0];
    assign w_req.acc_high = i_s_tdata[63:32];
    assign w_req.divisor  = i_s_tdata[95:64];

    // Magnitudes, divide-by-zero and the high-half overflow check.
    xdu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_s_tvalid),
        .i_req   (w_req),
        .o_valid (w_valid[0]),
        .o_stage (w_stage[0])
    );

    // The cell row: each cell produces one quotient bit, most significant
    // first, and passes the partial remainder to its neighbour.
    for (genvar g = 0; g < xdu_pkg::N_CELLS; g++) begin : g_cell
        xdu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g + 1]),
            .o_stage (w_stage[g + 1])
        );
    end

    // Sign restoration, range checks and register merge.
    xdu_post u_post (
        .i_stage (w_stage[xdu_pkg::N_CELLS]),
        .o_res   (w_res)
    );

    assign w_push = w_adv & w_valid[xdu_pkg::N_CELLS];
    assign w_take = r_out_valid & i_m_tready;

    // Output register with a one-entry skid register behind it. The skid
    // register only fills while the output register holds an unaccepted
    // result, and it is drained first once that transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !w_take) begin
            if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !w_take) begin
            if (w_push) begin
                r_skid <= w_res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (w_push) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.new_acc_high, r_out.new_acc_low};
    assign o_m_tuser  = r_out.status;

endmodule
